// File: rtl/sdac_pkg.sv
// ----------------------------------------------------------------------------
// sdac_pkg: shared constants and types for the setpoint-to-DAC block
// Widths, register indexes and reset values of the configuration registers.
// ----------------------------------------------------------------------------
package sdac_pkg;

	localparam int DAC_BITS      = 12;
	localparam int SETPOINT_BITS = 16;

	localparam int CNT_W   = 16;	// tick counter and comp_ticks
	localparam int GAIN_W  = 18;	// unsigned Q2.16
	localparam int FRAC_W  = 16;
	localparam int CFG_W   = 18;	// widest register
	localparam int IDX_W   = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_COMP_TICKS    = 3'd0,
		REG_COMP_MIN      = 3'd1,
		REG_CUR_BUF_THR   = 3'd2,
		REG_VOLT_BUF_THR  = 3'd3,
		REG_CUR_GAIN      = 3'd4,
		REG_VOLT_GAIN     = 3'd5
	} cfg_reg_t;

	localparam logic [CNT_W-1:0]         RST_COMP_TICKS   = CNT_W'(100);
	localparam logic [SETPOINT_BITS-1:0] RST_COMP_MIN     = SETPOINT_BITS'(30);
	localparam logic [SETPOINT_BITS-1:0] RST_CUR_BUF_THR  = SETPOINT_BITS'(100);
	localparam logic [SETPOINT_BITS-1:0] RST_VOLT_BUF_THR = SETPOINT_BITS'(10);
	localparam logic [GAIN_W-1:0]        RST_CUR_GAIN     = GAIN_W'(44728);	// ~0.6825
	localparam logic [GAIN_W-1:0]        RST_VOLT_GAIN    = GAIN_W'(89457);	// ~1.365

endpackage

// File: rtl/supply_setpoint_to_dac_with_compensation.sv
// ----------------------------------------------------------------------------
// supply_setpoint_to_dac_with_compensation: setpoints to DAC codes
// Converts voltage and current setpoints into held DAC codes, with a latched
// current compensation in constant-current mode.
// ----------------------------------------------------------------------------
// Usage
//   One input word per control tick on in_valid/in_stall carries both
//   setpoints, the measured current and the request and CC-mode flags. One
//   result word per input leaves on out_valid/out_stall with both held DAC
//   codes, the rewrite flags, the buffer enables and request_consumed.
//   The word lands in the input register, then one pass of compare, add,
//   a 17x18 multiply, rounding and saturation leads into the result and
//   state registers. A new word is taken every cycle while the result
//   side flows.
//   When the receiver stalls, the result register holds; the input register
//   takes one more word and then in_stall rises until the result is taken.
//   Reset clears both stages, all held codes, setpoint history, counter,
//   compensation and buffer enables, and loads the configuration registers
//   with their default values. Write configuration through cfg_write,
//   cfg_index and cfg_data only while no word is in flight; unknown indexes
//   are ignored.
// ----------------------------------------------------------------------------
module supply_setpoint_to_dac_with_compensation
	import sdac_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_write,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SETPOINT_BITS-1:0] set_voltage,
	input  logic [SETPOINT_BITS-1:0] set_current,
	input  logic [SETPOINT_BITS-1:0] measured_current,
	input  logic                     update_request,
	input  logic                     cc_mode,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [DAC_BITS-1:0]      current_code,
	output logic [DAC_BITS-1:0]      voltage_code,
	output logic                     current_written,
	output logic                     voltage_written,
	output logic                     current_buffer_on,
	output logic                     voltage_buffer_on,
	output logic                     request_consumed
);

	localparam int SP_W    = SETPOINT_BITS;
	localparam int SUM_W   = SP_W + 1;
	localparam int PROD_W  = SUM_W + GAIN_W;
	localparam int C_W     = PROD_W - FRAC_W;
	localparam int CMP_W   = (C_W > DAC_BITS) ? C_W : DAC_BITS;
	localparam logic [PROD_W-1:0]   RND     = PROD_W'(1) << (FRAC_W - 1);
	localparam logic [DAC_BITS-1:0] DAC_MAX = '1;

	// sum times gain, round half up, saturate
	function automatic logic [DAC_BITS-1:0] scale_code(
		input logic [SUM_W-1:0]  sum,
		input logic [GAIN_W-1:0] gain
	);
		logic [PROD_W-1:0] prod;
		logic [C_W-1:0]    c;
		prod = PROD_W'(sum) * PROD_W'(gain) + RND;
		c = prod[PROD_W-1:FRAC_W];
		if (CMP_W'(c) > CMP_W'(DAC_MAX)) begin
			scale_code = DAC_MAX;
		end else begin
			scale_code = DAC_BITS'(c);
		end
	endfunction

	// configuration registers
	logic [CNT_W-1:0]  comp_ticks_q;
	logic [SP_W-1:0]   comp_min_q;
	logic [SP_W-1:0]   cur_buf_thr_q;
	logic [SP_W-1:0]   volt_buf_thr_q;
	logic [GAIN_W-1:0] cur_gain_q;
	logic [GAIN_W-1:0] volt_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_ticks_q   <= RST_COMP_TICKS;
			comp_min_q     <= RST_COMP_MIN;
			cur_buf_thr_q  <= RST_CUR_BUF_THR;
			volt_buf_thr_q <= RST_VOLT_BUF_THR;
			cur_gain_q     <= RST_CUR_GAIN;
			volt_gain_q    <= RST_VOLT_GAIN;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_COMP_TICKS:   comp_ticks_q   <= cfg_data[CNT_W-1:0];
				REG_COMP_MIN:     comp_min_q     <= cfg_data[SP_W-1:0];
				REG_CUR_BUF_THR:  cur_buf_thr_q  <= cfg_data[SP_W-1:0];
				REG_VOLT_BUF_THR: volt_buf_thr_q <= cfg_data[SP_W-1:0];
				REG_CUR_GAIN:     cur_gain_q     <= cfg_data[GAIN_W-1:0];
				REG_VOLT_GAIN:    volt_gain_q    <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic            valid_s1;
	logic [SP_W-1:0] sv_s1;
	logic [SP_W-1:0] sc_s1;
	logic [SP_W-1:0] ac_s1;
	logic            req_s1;
	logic            cc_s1;
	logic            valid_s2;
	logic            adv;
	logic            in_take;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sv_s1  <= set_voltage;
			sc_s1  <= set_current;
			ac_s1  <= measured_current;
			req_s1 <= update_request;
			cc_s1  <= cc_mode;
		end
	end

	// state
	logic [SP_W-1:0]         last_v_q;
	logic [SP_W-1:0]         last_c_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SP_W:0]    comp_q;
	logic [DAC_BITS-1:0]     held_c_q;
	logic [DAC_BITS-1:0]     held_v_q;
	logic                    buf_c_q;
	logic                    buf_v_q;
	logic                    cw_s2;
	logic                    vw_s2;
	logic                    consumed_s2;

	// compensation step
	logic                    counting;
	logic [CNT_W-1:0]        cnt_inc;
	logic                    hit;
	logic signed [SP_W:0]    comp_lat;
	logic signed [SP_W:0]    comp_nxt;
	logic [CNT_W-1:0]        cnt_nxt;
	logic [SP_W-1:0]         last_c_eff;
	// code computation
	logic                    cw;
	logic                    vw;
	logic signed [SP_W+1:0]  sum_c;
	logic [SUM_W-1:0]        sum_c_pos;
	logic [SUM_W-1:0]        sum_v;
	logic [DAC_BITS-1:0]     code_c;
	logic [DAC_BITS-1:0]     code_v_raw;
	logic [DAC_BITS-1:0]     code_v;

	always_comb begin
		counting = req_s1 && cc_s1;
		cnt_inc  = cnt_q + CNT_W'(1);
		hit      = counting && (cnt_inc >= comp_ticks_q);
		if (sc_s1 >= comp_min_q) begin
			comp_lat = $signed({1'b0, sc_s1}) - $signed({1'b0, ac_s1});
		end else begin
			comp_lat = '0;
		end
		if (!counting) begin
			comp_nxt = '0;
			cnt_nxt  = cnt_q;
		end else if (hit) begin
			comp_nxt = comp_lat;
			cnt_nxt  = '0;
		end else begin
			comp_nxt = comp_q;
			cnt_nxt  = cnt_inc;
		end
		// force a current rewrite for a nonzero setpoint by dropping the setpoint history
		last_c_eff = hit ? '0 : last_c_q;

		cw    = (last_c_eff != sc_s1);
		vw    = (last_v_q != sv_s1);
		sum_c = $signed({2'b00, sc_s1}) + $signed({comp_nxt[SP_W], comp_nxt});
		sum_c_pos = sum_c[SP_W+1] ? '0 : sum_c[SUM_W-1:0];
		sum_v     = (sv_s1 == '0) ? SUM_W'(1) : {1'b0, sv_s1};
		code_c     = scale_code(sum_c_pos, cur_gain_q);
		code_v_raw = scale_code(sum_v, volt_gain_q);
		code_v     = (code_v_raw == '0) ? DAC_BITS'(1) : code_v_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			cw_s2       <= 1'b0;
			vw_s2       <= 1'b0;
			consumed_s2 <= 1'b0;
			last_v_q    <= '0;
			last_c_q    <= '0;
			cnt_q       <= '0;
			comp_q      <= '0;
			held_c_q    <= '0;
			held_v_q    <= '0;
			buf_c_q     <= 1'b0;
			buf_v_q     <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (adv) begin
				cw_s2       <= cw;
				vw_s2       <= vw;
				consumed_s2 <= hit;
				cnt_q       <= cnt_nxt;
				comp_q      <= comp_nxt;
				last_c_q    <= sc_s1;
				last_v_q    <= sv_s1;
				if (cw) begin
					held_c_q <= code_c;
					buf_c_q  <= (sc_s1 >= cur_buf_thr_q);
				end
				if (vw) begin
					held_v_q <= code_v;
					buf_v_q  <= (sv_s1 >= volt_buf_thr_q);
				end
			end
		end
	end

	assign out_valid         = valid_s2;
	assign current_code      = held_c_q;
	assign voltage_code      = held_v_q;
	assign current_written   = cw_s2;
	assign voltage_written   = vw_s2;
	assign current_buffer_on = buf_c_q;
	assign voltage_buffer_on = buf_v_q;
	assign request_consumed  = consumed_s2;

	// checks
	a_consume_clears_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		adv && hit |=> cnt_q == '0)
		else $error("counter not cleared after consuming request");

	a_history_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (last_c_q == $past(sc_s1)) && (last_v_q == $past(sv_s1)))
		else $error("setpoint history out of step");

	a_volt_code_floor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && vw_s2 |-> held_v_q != '0)
		else $error("voltage code below floor after rewrite");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with empty input register");

	a_comp_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !counting |=> comp_q == '0)
		else $error("compensation kept outside counting");

endmodule
